[hdl/smr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the scatter-min lane block.
package smr_pkg;

    localparam int NODE_BITS  = 14;
    localparam int NODE_IDX_W = 13;
    localparam int SKIP_BIT   = 13;
    localparam int VALUE_W    = 32;
    localparam int DRAIN_W    = 12;
    localparam int WORD_BITS  = 64;
    localparam int INPUT_LANES = 4;

    localparam logic       OP_SCATTER = 1'b0;
    localparam logic       OP_DRAIN   = 1'b1;
    localparam logic [31:0] INF_RESET = 32'hFFFF_FFFF;

    // Step strobes from the sequencer to every lane.
    typedef struct packed {
        logic div;      // latch quotient / skip / value
        logic modq;     // latch wrap quotient and slot
        logic addr;     // latch word address, issue memory read
        logic commit;   // write back
        logic clear;    // write zero at the sweep address
        logic drain;    // current word is a drain
    } lane_ctrl_t;

endpackage

[hdl/smr_in_if.sv]
`timescale 1ns / 1ps
// Input channel: scatter or drain word with valid/ready.
interface smr_in_if import smr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [NODE_BITS-1:0] lane0_node;
    logic [NODE_BITS-1:0] lane1_node;
    logic [NODE_BITS-1:0] lane2_node;
    logic [NODE_BITS-1:0] lane3_node;
    logic [VALUE_W-1:0]   lane0_value;
    logic [VALUE_W-1:0]   lane1_value;
    logic [VALUE_W-1:0]   lane2_value;
    logic [VALUE_W-1:0]   lane3_value;
    logic [DRAIN_W-1:0]   drain_addr;

    modport source (
        output valid, op, lane0_node, lane1_node, lane2_node, lane3_node,
               lane0_value, lane1_value, lane2_value, lane3_value, drain_addr,
        input  ready
    );
    modport sink (
        input  valid, op, lane0_node, lane1_node, lane2_node, lane3_node,
               lane0_value, lane1_value, lane2_value, lane3_value, drain_addr,
        output ready
    );
endinterface

[hdl/smr_out_if.sv]
`timescale 1ns / 1ps
// Output channel: merged drain word with valid/ready.
interface smr_out_if import smr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] min_word;

    modport source (output valid, min_word, input ready);
    modport sink   (input valid, min_word, output ready);
endinterface

[hdl/smr_lane.sv]
`timescale 1ns / 1ps
// One lane: address arithmetic, value store and min read-modify-write.
module smr_lane import smr_pkg::*; #(
    parameter int WORDS_PER_LANE  = 4096,
    parameter int VALUES_PER_WORD = 2,
    parameter int VALUE_BITS      = 32,
    parameter bit HAS_INPUT       = 1'b1,
    localparam int AW = $clog2(WORDS_PER_LANE),
    localparam int SLOTS_STORED = (VALUES_PER_WORD * VALUE_BITS > WORD_BITS) ?
                                  WORD_BITS / VALUE_BITS : VALUES_PER_WORD,
    localparam int STORE_BITS = SLOTS_STORED * VALUE_BITS
) (
    input  logic                  clk,
    input  lane_ctrl_t            ctrl,
    input  logic [AW-1:0]         clr_addr,
    input  logic [NODE_BITS-1:0]  node,
    input  logic [VALUE_W-1:0]    value,
    input  logic [DRAIN_W-1:0]    drain_addr,
    output logic [STORE_BITS-1:0] rdata
);

    localparam int SLOT_W = (VALUES_PER_WORD > 1) ? $clog2(VALUES_PER_WORD) : 1;
    // floor(n / VALUES_PER_WORD) for n < 2^13 via reciprocal, 16-bit fraction
    localparam int unsigned RECIP_V = ((1 << 16) + VALUES_PER_WORD - 1) / VALUES_PER_WORD;
    // floor(q / WORDS_PER_LANE) for q < 2^13, 30-bit fraction
    localparam longint unsigned RECIP_W =
        ((64'd1 << 30) + longint'(WORDS_PER_LANE) - 1) / longint'(WORDS_PER_LANE);

    logic [STORE_BITS-1:0] mem [WORDS_PER_LANE];

    logic [NODE_IDX_W-1:0] q_reg, q_next;
    logic [NODE_IDX_W-1:0] t_reg, t_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  skip_reg, skip_next;
    logic [STORE_BITS-1:0] rdata_reg;
    logic [STORE_BITS-1:0] upd_word;

    logic [29:0] qv_prod;
    logic [43:0] t_prod;
    logic [15:0] slot_full;
    logic [31:0] addr_full;
    logic [VALUE_BITS-1:0] cur;

    always_comb
    begin
        qv_prod   = 30'(node[NODE_IDX_W-1:0]) * 30'(RECIP_V);
        q_next    = ctrl.drain ? NODE_IDX_W'(drain_addr) : qv_prod[28:16];
        skip_next = (ctrl.drain == OP_SCATTER) && (node[SKIP_BIT] || !HAS_INPUT);
        t_prod    = 44'(q_reg) * 44'(RECIP_W);
        t_next    = t_prod[42:30];
        slot_full = 16'(node[NODE_IDX_W-1:0]) - 16'(q_reg) * 16'(VALUES_PER_WORD);
        slot_next = slot_full[SLOT_W-1:0];
        addr_full = 32'(q_reg) - 32'(t_reg) * 32'(WORDS_PER_LANE);
        addr_next = addr_full[AW-1:0];
    end

    // min update; a slot index beyond the stored slots leaves the word as is
    always_comb
    begin
        upd_word = rdata_reg;
        cur      = '0;
        for (int s = 0; s < SLOTS_STORED; s++)
        begin
            if (SLOT_W'(s) == slot_reg)
            begin
                cur = rdata_reg[s*VALUE_BITS +: VALUE_BITS];
                upd_word[s*VALUE_BITS +: VALUE_BITS] =
                    (cur != '0 && cur < val_reg) ? cur : val_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.div)
        begin
            q_reg    <= q_next;
            skip_reg <= skip_next;
            val_reg  <= value[VALUE_BITS-1:0];
        end
        if (ctrl.modq)
        begin
            t_reg    <= t_next;
            slot_reg <= slot_next;
        end
        if (ctrl.addr)
        begin
            addr_reg  <= addr_next;
            rdata_reg <= mem[addr_next];
        end
        if (ctrl.commit)
        begin
            if (ctrl.clear)
                mem[clr_addr] <= '0;
            else if (ctrl.drain)
                mem[addr_reg] <= '0;
            else if (!skip_reg)
                mem[addr_reg] <= upd_word;
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/smr_merge.sv]
`timescale 1ns / 1ps
// Per-slot minimum of nonzero lane values, seeded with infinity.
module smr_merge import smr_pkg::*; #(
    parameter int LANES           = 4,
    parameter int VALUES_PER_WORD = 2,
    parameter int VALUE_BITS      = 32,
    localparam int SLOTS_STORED = (VALUES_PER_WORD * VALUE_BITS > WORD_BITS) ?
                                  WORD_BITS / VALUE_BITS : VALUES_PER_WORD,
    localparam int STORE_BITS = SLOTS_STORED * VALUE_BITS
) (
    input  logic [LANES-1:0][STORE_BITS-1:0] words,
    input  logic [VALUE_BITS-1:0]            infinity,
    output logic [WORD_BITS-1:0]             merged
);

    logic [VALUE_BITS-1:0] acc [SLOTS_STORED];
    logic [VALUE_BITS-1:0] v;

    always_comb
    begin
        merged = '0;
        v      = '0;
        for (int s = 0; s < SLOTS_STORED; s++)
        begin
            acc[s] = infinity;
            for (int l = 0; l < LANES; l++)
            begin
                v = words[l][s*VALUE_BITS +: VALUE_BITS];
                if (v != '0 && v < acc[s])
                    acc[s] = v;
            end
            merged[s*VALUE_BITS +: VALUE_BITS] = acc[s];
        end
    end

endmodule

[hdl/scatter_min_reduce_lanes_core.sv]
`timescale 1ns / 1ps
// Scatter-min lane block: LANES value stores, min scatter updates, drain with merge.
//
// in_ch (sink): one word per item. op = scatter updates each input lane's slot
//   (node / VALUES_PER_WORD, node % VALUES_PER_WORD) with the unsigned min,
//   an empty (zero) slot simply takes the value; node bit 13 skips the lane.
//   op = drain reads word drain_addr from every lane, clears it there and
//   returns one merged word on out_ch.
// out_ch (source): min_word, per-slot min of nonzero lane values and the
//   infinity register; unused upper bits are zero. Held until taken.
// cfg_we / cfg_wdata: write of the infinity register (resets to all ones).
// Timing: an item passes through accept, quotient, wrap/slot, address and
//   memory read, and write-back, set by the address reciprocal multiplies and
//   the registered memory read that each lane steps through in turn. A drain's
//   word is latched at its write-back; the next item is accepted after it.
// Reset: after rst_n rises the stores are swept to zero, one word per cycle
//   in all lanes at once, through all WORDS_PER_LANE words; in_ch.ready stays low.
// Stall: a finished word waits in the output register; the next item is
//   accepted meanwhile and only a following drain holds at write-back until
//   the output register is free.
module scatter_min_reduce_lanes_core import smr_pkg::*; #(
    parameter int LANES           = 4,
    parameter int WORDS_PER_LANE  = 4096,
    parameter int VALUES_PER_WORD = 2,
    parameter int VALUE_BITS      = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [31:0]   cfg_wdata,
    smr_in_if.sink        in_ch,
    smr_out_if.source     out_ch
);

    localparam int AW = $clog2(WORDS_PER_LANE);
    localparam int SLOTS_STORED = (VALUES_PER_WORD * VALUE_BITS > WORD_BITS) ?
                                  WORD_BITS / VALUE_BITS : VALUES_PER_WORD;
    localparam int STORE_BITS = SLOTS_STORED * VALUE_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MOD,
        ST_ADDR,
        ST_UPD
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] out_word_reg, out_word_next;
    logic [31:0]          inf_reg, inf_next;

    // captured item (payload, no reset)
    logic                 op_reg;
    logic [NODE_BITS-1:0] node_reg  [INPUT_LANES];
    logic [VALUE_W-1:0]   value_reg [INPUT_LANES];
    logic [DRAIN_W-1:0]   drain_addr_reg;

    lane_ctrl_t                      ctrl;
    logic [LANES-1:0][STORE_BITS-1:0] lane_words;
    logic [WORD_BITS-1:0]            merged;
    logic                            accept;
    logic                            advance;

    assign accept  = in_ch.valid && in_ch.ready;
    // a drain may only write back once its result has a place to go
    assign advance = (op_reg == OP_SCATTER) || !out_valid_reg || out_ch.ready;

    always_comb
    begin
        ctrl.div    = (state_reg == ST_DIV);
        ctrl.modq   = (state_reg == ST_MOD);
        ctrl.addr   = (state_reg == ST_ADDR);
        ctrl.clear  = (state_reg == ST_CLEAR);
        ctrl.commit = (state_reg == ST_CLEAR) || (state_reg == ST_UPD && advance);
        ctrl.drain  = op_reg;
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        if (i < INPUT_LANES)
        begin : g_in
            smr_lane #(
                .WORDS_PER_LANE  (WORDS_PER_LANE),
                .VALUES_PER_WORD (VALUES_PER_WORD),
                .VALUE_BITS      (VALUE_BITS),
                .HAS_INPUT       (1'b1)
            ) u_lane (
                .clk        (clk),
                .ctrl       (ctrl),
                .clr_addr   (clr_cnt_reg),
                .node       (node_reg[i]),
                .value      (value_reg[i]),
                .drain_addr (drain_addr_reg),
                .rdata      (lane_words[i])
            );
        end
        else
        begin : g_noin
            // lanes past the input fields only ever read back empty
            smr_lane #(
                .WORDS_PER_LANE  (WORDS_PER_LANE),
                .VALUES_PER_WORD (VALUES_PER_WORD),
                .VALUE_BITS      (VALUE_BITS),
                .HAS_INPUT       (1'b0)
            ) u_lane (
                .clk        (clk),
                .ctrl       (ctrl),
                .clr_addr   (clr_cnt_reg),
                .node       ('0),
                .value      ('0),
                .drain_addr (drain_addr_reg),
                .rdata      (lane_words[i])
            );
        end
    end

    smr_merge #(
        .LANES           (LANES),
        .VALUES_PER_WORD (VALUES_PER_WORD),
        .VALUE_BITS      (VALUE_BITS)
    ) u_merge (
        .words    (lane_words),
        .infinity (inf_reg[VALUE_BITS-1:0]),
        .merged   (merged)
    );

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        inf_next       = cfg_we ? cfg_wdata : inf_reg;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(WORDS_PER_LANE - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DIV;
            end
            ST_DIV:  state_next = ST_MOD;
            ST_MOD:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_UPD;
            ST_UPD:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                    if (op_reg == OP_DRAIN)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = merged;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            inf_reg       <= INF_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
            inf_reg       <= inf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= in_ch.op;
            node_reg[0]    <= in_ch.lane0_node;
            node_reg[1]    <= in_ch.lane1_node;
            node_reg[2]    <= in_ch.lane2_node;
            node_reg[3]    <= in_ch.lane3_node;
            value_reg[0]   <= in_ch.lane0_value;
            value_reg[1]   <= in_ch.lane1_value;
            value_reg[2]   <= in_ch.lane2_value;
            value_reg[3]   <= in_ch.lane3_value;
            drain_addr_reg <= in_ch.drain_addr;
        end
    end

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.min_word = out_word_reg;

endmodule

[hdl/smr_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the scatter-min lane block, bound to the top level.
module smr_checker import smr_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [WORD_BITS-1:0] min_word
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // one item in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input accepted while previous word still in flight");

    // a fresh result follows an accepted word by the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_acc, 5))
        else $error("result word without matching accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(min_word))
        else $error("output word changed while stalled");

endmodule

bind scatter_min_reduce_lanes_core smr_checker u_smr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .min_word  (out_ch.min_word)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the scatter-min lane block: random and directed words, scoreboard.
module testbench import smr_pkg::*;;

    // Block configuration as instantiated below.
    localparam int LANES      = 4;
    localparam int WORDS      = 4096;
    localparam int VPW        = 2;
    localparam int VBITS      = 32;

    // Settling pause after the last expected word.
    localparam int SETTLE_CYCLES   = 20;
    // No-handshake watchdog; must cover the store sweep after reset.
    localparam int IDLE_LIMIT      = 20000;
    // Long receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_PER_PHASE = 325;
    localparam int PHASES          = 5;
    localparam int MAX_PRINTS      = 40;

    // One input word as seen on in_ch.
    typedef struct packed {
        logic                                   op;
        logic [INPUT_LANES-1:0][NODE_BITS-1:0]  node;
        logic [INPUT_LANES-1:0][VALUE_W-1:0]    value;
        logic [DRAIN_W-1:0]                     drain_addr;
    } lane_word_t;

    // Shadow of the lane stores plus the queue of merged words still owed by the block.
    class min_scoreboard;
        logic [WORD_BITS-1:0] lane_store [LANES][WORDS];
        logic [VALUE_W-1:0]   infinity;
        logic [WORD_BITS-1:0] owed_words [$];
        int                   errors;

        function new();
            foreach (lane_store[l, a])
                lane_store[l][a] = '0;
            infinity = INF_RESET;
            errors   = 0;
        endfunction

        function void set_infinity(logic [VALUE_W-1:0] v);
            infinity = v;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        task report(string what, logic [WORD_BITS-1:0] got, logic [WORD_BITS-1:0] want);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t ns: %s got %h want %h", $time, what, got, want);
        endtask

        // Apply an accepted word to the shadow stores; a drain owes one merged word.
        function void note_input(lane_word_t w);
            int                   addr;
            int                   slot;
            logic [VALUE_W-1:0]   cur;
            logic [VALUE_W-1:0]   cand;
            logic [VALUE_W-1:0]   acc;
            logic [WORD_BITS-1:0] merged;
            if (w.op == OP_SCATTER) begin
                for (int l = 0; l < INPUT_LANES; l++) begin
                    if (w.node[l][SKIP_BIT])
                        continue;
                    addr = (int'(w.node[l][NODE_IDX_W-1:0]) / VPW) % WORDS;
                    slot = int'(w.node[l][NODE_IDX_W-1:0]) % VPW;
                    cur  = lane_store[l][addr][slot*VBITS +: VBITS];
                    cand = w.value[l];
                    if (cur != '0 && cur < cand)
                        cand = cur;
                    lane_store[l][addr][slot*VBITS +: VBITS] = cand;
                end
            end
            else begin
                addr   = int'(w.drain_addr) % WORDS;
                merged = '0;
                for (int s = 0; s < VPW; s++) begin
                    acc = infinity;
                    for (int l = 0; l < LANES; l++) begin
                        cur = lane_store[l][addr][s*VBITS +: VBITS];
                        if (cur != '0 && cur < acc)
                            acc = cur;
                    end
                    merged[s*VBITS +: VBITS] = acc;
                end
                for (int l = 0; l < LANES; l++)
                    lane_store[l][addr] = '0;
                owed_words.push_back(merged);
            end
        endfunction

        task check_result(logic [WORD_BITS-1:0] got);
            logic [WORD_BITS-1:0] want;
            if (owed_words.size() == 0) begin
                report("unexpected min_word", got, '0);
            end
            else begin
                want = owed_words.pop_front();
                if (got !== want)
                    report("min_word", got, want);
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    smr_in_if  in_ch();
    smr_out_if out_ch();

    min_scoreboard sb;

    // Shared pacing knobs: quiet turns off all random idling, hold_req asks the
    // receiver for one long hold-off.
    bit quiet;
    bit hold_req;
    int hot_pool [16];

    scatter_min_reduce_lanes_core #(
        .LANES           (LANES),
        .WORDS_PER_LANE  (WORDS),
        .VALUES_PER_WORD (VPW),
        .VALUE_BITS      (VBITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long; none in quiet stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Word addresses that scatters and drains mostly aim at, so that drains
    // find populated words; both ends of the store are always in the pool.
    task refill_hot_pool();
        foreach (hot_pool[i])
            hot_pool[i] = $urandom_range(0, WORDS - 1);
        hot_pool[0] = 0;
        hot_pool[1] = WORDS - 1;
    endtask

    function automatic lane_word_t scatter_word(
        logic [NODE_BITS-1:0] n0, logic [NODE_BITS-1:0] n1,
        logic [NODE_BITS-1:0] n2, logic [NODE_BITS-1:0] n3,
        logic [VALUE_W-1:0] v0, logic [VALUE_W-1:0] v1,
        logic [VALUE_W-1:0] v2, logic [VALUE_W-1:0] v3);
        lane_word_t w;
        w.op         = OP_SCATTER;
        w.node       = {n3, n2, n1, n0};
        w.value      = {v3, v2, v1, v0};
        w.drain_addr = DRAIN_W'($urandom());
        return w;
    endfunction

    // Drain word; the unused node/value fields carry noise.
    function automatic lane_word_t drain_word(logic [DRAIN_W-1:0] addr);
        lane_word_t w;
        w.op = OP_DRAIN;
        for (int l = 0; l < INPUT_LANES; l++) begin
            w.node[l]  = NODE_BITS'($urandom());
            w.value[l] = $urandom();
        end
        w.drain_addr = addr;
        return w;
    endfunction

    function automatic lane_word_t random_word(int drain_pct);
        lane_word_t w;
        int         r;
        w = drain_word(($urandom_range(0, 99) < 80) ? DRAIN_W'(hot_pool[$urandom_range(0, 15)])
                                                      : DRAIN_W'($urandom()));
        if ($urandom_range(0, 99) < drain_pct)
            return w;
        w.op = OP_SCATTER;
        for (int l = 0; l < INPUT_LANES; l++) begin
            r = $urandom_range(0, 99);
            if (r < 10)
                w.node[l] = {1'b1, NODE_IDX_W'($urandom())};          // lane skipped
            else if (r < 85)
                w.node[l] = {1'b0, DRAIN_W'(hot_pool[$urandom_range(0, 15)]),
                             1'($urandom_range(0, 1))};
            else
                w.node[l] = {1'b0, NODE_IDX_W'($urandom())};
            r = $urandom_range(0, 99);
            if (r < 20)
                w.value[l] = $urandom_range(1, 16);
            else if (r < 30)
                w.value[l] = '0;                                    // zero candidate
            else if (r < 35)
                w.value[l] = '1;
            else if (r < 40)
                w.value[l] = sb.infinity + $urandom_range(0, 4) - 2;  // straddle infinity
            else
                w.value[l] = $urandom();
        end
        return w;
    endfunction

    // Offer one word and return in the time step of its acceptance; valid stays
    // high so that a back-to-back word follows with no bubble.
    task send_word(lane_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= w.op;
        in_ch.lane0_node  <= w.node[0];
        in_ch.lane1_node  <= w.node[1];
        in_ch.lane2_node  <= w.node[2];
        in_ch.lane3_node  <= w.node[3];
        in_ch.lane0_value <= w.value[0];
        in_ch.lane1_value <= w.value[1];
        in_ch.lane2_value <= w.value[2];
        in_ch.lane3_value <= w.value[3];
        in_ch.drain_addr  <= w.drain_addr;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Stop offering, let the monitor log the last accept, wait for every owed
    // word, then give trailing scatters time to finish their write-back.
    task settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_infinity(logic [31:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_infinity(v);
    endtask

    // Extremes and the corner cases: empty drain, min into a full slot, zero
    // into an empty and into a full slot, skip bit, top and bottom addresses.
    task run_directed();
        send_word(drain_word(12'h000));                             // all empty -> infinity
        send_word(scatter_word(14'h0000, 14'h0001, 14'h0000, 14'h2001,
                               32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7));
        send_word(scatter_word(14'h0000, 14'h0001, 14'h0001, 14'h0000,
                               32'h5, 32'h10, 32'h0, 32'hAAAA_AAAA));
        send_word(drain_word(12'h000));
        send_word(drain_word(12'h000));                             // cleared by the last drain
        send_word(scatter_word(14'h1FFF, 14'h1FFE, 14'h1FFF, 14'h3FFF,
                               32'h5555_5555, 32'hFFFF_FFFF, 32'h3, 32'hFFFF_FFFF));
        send_word(scatter_word(14'h3FFE, 14'h2000, 14'h1FFF, 14'h3FFF,
                               32'h1, 32'h1, 32'h0, 32'h1));        // zero into a full slot
        send_word(drain_word(12'hFFF));
        send_word(drain_word(12'hFFF));
        send_word(scatter_word(14'h0002, 14'h0002, 14'h0003, 14'h0003,
                               32'h9, 32'h8, 32'h7, 32'h6));
        send_word(scatter_word(14'h0002, 14'h0003, 14'h0002, 14'h0003,
                               32'hFFFF_FFFE, 32'h6, 32'h1, 32'h0000_0006));
        send_word(drain_word(12'h001));
        send_word(scatter_word(14'h0AAA, 14'h1555, 14'h0AAB, 14'h1554,
                               32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h8000_0000));
        send_word(scatter_word(14'h0AAA, 14'h1555, 14'h0AAB, 14'h1554,
                               32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send_word(drain_word(12'h555));
        send_word(drain_word(12'hAAA));
        send_word(drain_word(12'hAAA));
    endtask

    // Main sequence: reset, then phases at different infinity settings, with a
    // back-pressure episode in the middle one.
    initial
    begin : stimulus
        logic [31:0] inf_plan [PHASES];
        sb = new();
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= INF_RESET;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_SCATTER;
        in_ch.lane0_node  <= '0;
        in_ch.lane1_node  <= '0;
        in_ch.lane2_node  <= '0;
        in_ch.lane3_node  <= '0;
        in_ch.lane0_value <= '0;
        in_ch.lane1_value <= '0;
        in_ch.lane2_value <= '0;
        in_ch.lane3_value <= '0;
        in_ch.drain_addr  <= '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        inf_plan[0] = INF_RESET;
        inf_plan[1] = 32'h0;
        inf_plan[2] = 32'h9;          // inside the small-value band
        inf_plan[3] = $urandom();
        inf_plan[4] = INF_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            write_infinity(inf_plan[phase]);
            refill_hot_pool();
            if (phase == 0)
                run_directed();
            if (phase == 2) begin
                // Receiver stalls for a long stretch while words keep coming,
                // half of them drains, so the block backs up into its input.
                quiet    = 1'b1;
                hold_req = 1'b1;
                repeat (40) send_word(random_word(50));
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 50 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                send_word(random_word(30));
            end
        end
        quiet = 1'b0;
        settle();

        if (sb.errors == 0)
            $display("scatter_min_reduce_lanes_core: match");
        else
            $display("scatter_min_reduce_lanes_core: mismatch");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off counted here on request.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (stall_left == 0 && hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: both handshakes are sampled at the clock edge that completes
    // them; the watchdog counts edges with no word moving on either side.
    always @(posedge clk)
    begin : monitor
        lane_word_t seen;
        int         idle_cycles;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                seen.op         = in_ch.op;
                seen.node[0]    = in_ch.lane0_node;
                seen.node[1]    = in_ch.lane1_node;
                seen.node[2]    = in_ch.lane2_node;
                seen.node[3]    = in_ch.lane3_node;
                seen.value[0]   = in_ch.lane0_value;
                seen.value[1]   = in_ch.lane1_value;
                seen.value[2]   = in_ch.lane2_value;
                seen.value[3]   = in_ch.lane3_value;
                seen.drain_addr = in_ch.drain_addr;
                sb.note_input(seen);
            end
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.min_word);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d cycles without a handshake", idle_cycles);
                $display("scatter_min_reduce_lanes_core: mismatch");
                $finish;
            end
        end
        else begin
            idle_cycles = 0;
        end
    end

endmodule

[filelist.f]
hdl/smr_pkg.sv
hdl/smr_in_if.sv
hdl/smr_out_if.sv
hdl/smr_lane.sv
hdl/smr_merge.sv
hdl/scatter_min_reduce_lanes_core.sv
hdl/smr_checker.sv
dv/testbench.sv
